// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the label filter.
// Depends on nothing; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ULF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ULF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ULF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ULF_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/ulf_pkg.sv -----
// Types, constants and the accent fold table of the UTF-8 label filter.
// Depends on nothing; used by the step logic and the top level.
package ulf_pkg;

   localparam logic [7:0] MAX_CHARS_RESET = 8'd24;

   localparam logic [7:0] MASK_CONT  = 8'hC0;
   localparam logic [7:0] CODE_CONT  = 8'h80;
   localparam logic [7:0] MASK_LEAD2 = 8'hE0;
   localparam logic [7:0] CODE_LEAD2 = 8'hC0;
   localparam logic [7:0] MASK_LEAD3 = 8'hF0;
   localparam logic [7:0] CODE_LEAD3 = 8'hE0;
   localparam logic [7:0] MASK_LEAD4 = 8'hF8;
   localparam logic [7:0] CODE_LEAD4 = 8'hF0;
   localparam logic [1:0] SKIP_LEAD3 = 2'd2;
   localparam logic [1:0] SKIP_LEAD4 = 2'd3;

   typedef struct packed {
      logic [4:0] pending_lead_bits;
      logic       pending_valid;
      logic [1:0] skip_left;
      logic [7:0] chars_written;
      logic       label_closed;
   } label_state_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       char_valid;
      logic       label_end;
      logic [7:0] label_length;
   } result_type;

   // Folds an accented Latin-1 code point to plain ASCII; zero means no match.
   function automatic logic [6:0] fold_lookup(input logic [10:0] code);
      logic [6:0] ch;
      ch = 7'h00;
      if (code[10:8] == 3'b000) begin
         unique case (code[7:0])
            8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4:        ch = 7'h41;
            8'hC7:                                    ch = 7'h43;
            8'hC8, 8'hC9, 8'hCA, 8'hCB:               ch = 7'h45;
            8'hCC, 8'hCD, 8'hCE, 8'hCF:               ch = 7'h49;
            8'hD1:                                    ch = 7'h4E;
            8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6:        ch = 7'h4F;
            8'hD9, 8'hDA, 8'hDB, 8'hDC:               ch = 7'h55;
            8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4:        ch = 7'h61;
            8'hE7:                                    ch = 7'h63;
            8'hE8, 8'hE9, 8'hEA, 8'hEB:               ch = 7'h65;
            8'hEC, 8'hED, 8'hEE, 8'hEF:               ch = 7'h69;
            8'hF1:                                    ch = 7'h6E;
            8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6:        ch = 7'h6F;
            8'hF9, 8'hFA, 8'hFB, 8'hFC:               ch = 7'h75;
            default:                                  ch = 7'h00;
         endcase
      end
      return ch;
   endfunction

endpackage

// ----- src/ulf_req_if.sv -----
// Input channel of the label filter: one raw UTF-8 byte per beat.
// Depends on nothing.
interface ulf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- src/ulf_rsp_if.sv -----
// Result channel of the label filter: one folded ASCII character or end mark per beat.
// Depends on nothing.
interface ulf_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       char_valid;
   logic       label_end;
   logic [7:0] label_length;

   modport source (output valid, output out_char, output char_valid,
                   output label_end, output label_length, input ready);
   modport sink   (input valid, input out_char, input char_valid,
                   input label_end, input label_length, output ready);
endinterface

// ----- src/utf8_latin_fold_filter_core.sv -----
// A result beat is registered in the result register after its byte has
// passed the input register and the decode step. Throughput: one byte per
// cycle unless a waiting result beat is held by the sink, set by the single
// decode step between the input register and the result register; the result
// register releases a waiting beat while the next byte is taken. Reset
// (synchronous, active high) clears the label state and both stages and sets the character limit to 24.
`include "assert_macros.svh"

module utf8_latin_fold_filter_core (
   input  logic         clock,
   input  logic         reset,
   ulf_req_if.sink      req_bus,
   ulf_rsp_if.source    rsp_bus,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);
   import ulf_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_last_ff, in_last_in;
   label_state_type state_ff, state_in;
   logic [7:0]      max_chars_ff, max_chars_in;
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff, out_data_in;

   label_state_type step_state;
   result_type      step_result;
   logic            step_emit;
   logic            in_fire;
   logic            step_fire;

   ulf_step u_step (
      .cur_state (state_ff),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .max_chars (max_chars_ff),
      .nxt_state (step_state),
      .result    (step_result),
      .emit      (step_emit)
   );

   assign step_fire     = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step_fire;
   assign in_fire       = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      state_in     = state_ff;
      max_chars_in = max_chars_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (in_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.in_byte;
         in_last_in  = req_bus.last_byte;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end

      if (step_fire) begin
         state_in     = step_state;
         out_valid_in = step_emit;
         out_data_in  = step_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         max_chars_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         max_chars_ff <= MAX_CHARS_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         max_chars_ff <= max_chars_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.out_char     = out_data_ff.out_char;
   assign rsp_bus.char_valid   = out_data_ff.char_valid;
   assign rsp_bus.label_end    = out_data_ff.label_end;
   assign rsp_bus.label_length = out_data_ff.label_length;

   `ULF_ASSERT_IMP(a_nochar_is_end, clock, reset,
      out_valid_ff && !out_data_ff.char_valid,
      out_data_ff.label_end && (out_data_ff.out_char == 7'h00))
   `ULF_ASSERT_NXT(a_end_clears, clock, reset, step_fire && in_last_ff,
      (state_ff.chars_written == 8'd0) && !state_ff.label_closed && !state_ff.pending_valid)
   `ULF_ASSERT_IMP(a_pend_no_skip, clock, reset, state_ff.pending_valid,
      state_ff.skip_left == 2'd0)

endmodule

// ----- src/ulf_step.sv -----
// Decoder step of the label filter: one byte against the label state.
// Depends on ulf_pkg for the state and result types and the fold table.
module ulf_step (
   input  ulf_pkg::label_state_type cur_state,
   input  logic [7:0]               in_byte,
   input  logic                     last_byte,
   input  logic [7:0]               max_chars,
   output ulf_pkg::label_state_type nxt_state,
   output ulf_pkg::result_type      result,
   output logic                     emit
);
   import ulf_pkg::*;

   always_comb begin
      label_state_type st;
      logic            produced;
      logic [6:0]      ch;
      logic            fresh;
      logic [10:0]     code;

      st       = cur_state;
      produced = 1'b0;
      ch       = 7'h00;
      fresh    = 1'b1;
      code     = {cur_state.pending_lead_bits, in_byte[5:0]};

      priority if (cur_state.label_closed || (cur_state.chars_written >= max_chars)) begin
         st.pending_valid     = 1'b0;
         st.pending_lead_bits = 5'd0;
         st.skip_left         = 2'd0;
      end else if (in_byte == 8'h00) begin
         st.label_closed      = 1'b1;
         st.pending_valid     = 1'b0;
         st.pending_lead_bits = 5'd0;
         st.skip_left         = 2'd0;
      end else if (cur_state.skip_left != 2'd0) begin
         st.skip_left = cur_state.skip_left - 2'd1;
      end else begin
         if (cur_state.pending_valid) begin
            st.pending_valid = 1'b0;
            if ((in_byte & MASK_CONT) == CODE_CONT) begin
               ch       = fold_lookup(code);
               produced = (ch != 7'h00);
               fresh    = 1'b0;
            end
            st.pending_lead_bits = 5'd0;
         end
         if (fresh) begin
            priority if (!in_byte[7]) begin
               ch       = in_byte[6:0];
               produced = 1'b1;
            end else if ((in_byte & MASK_LEAD2) == CODE_LEAD2) begin
               st.pending_valid     = 1'b1;
               st.pending_lead_bits = in_byte[4:0];
            end else if ((in_byte & MASK_LEAD3) == CODE_LEAD3) begin
               st.skip_left = SKIP_LEAD3;
            end else if ((in_byte & MASK_LEAD4) == CODE_LEAD4) begin
               st.skip_left = SKIP_LEAD4;
            end else begin
               st.skip_left = 2'd0;
            end
         end
      end

      if (produced) begin
         st.chars_written = cur_state.chars_written + 8'd1;
      end

      result.out_char     = produced ? ch : 7'h00;
      result.char_valid   = produced;
      result.label_end    = last_byte;
      result.label_length = st.chars_written;
      emit                = produced || last_byte;

      if (last_byte) begin
         nxt_state = '0;
      end else begin
         nxt_state = st;
      end
   end

endmodule
